>>> sv/rkst_pkg.sv
// Shared types, constants and helper functions of the RK4 streamline tracer.
// No dependencies; the RTL files refer to it by scoped names, the bench imports it.
package rkst_pkg;

	localparam int POS_W       = 24;
	localparam int VEC_W       = 16;
	localparam int UNIT_W      = 16;
	localparam int K_W         = 28;
	localparam int SUM_W       = 31;
	localparam int STEP_W      = 12;
	localparam int CNT_W       = 5;
	localparam int DIM_W       = 9;
	localparam int ADDR_W      = 16;
	localparam int COORD_W     = 8;
	localparam int PNUM_W      = 6;
	localparam int MAX_STEPS   = 31;
	localparam int MAX_FIELD_W = 256;
	localparam int MAX_FIELD_H = 256;
	localparam int FIELD_DEPTH = 65536;

	localparam logic [1:0] CFG_STEP_SIZE    = 2'd0;
	localparam logic [1:0] CFG_STEP_COUNT   = 2'd1;
	localparam logic [1:0] CFG_FIELD_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_FIELD_HEIGHT = 2'd3;

	localparam logic [STEP_W-1:0] STEP_SIZE_RST  = 12'd256;
	localparam logic [CNT_W-1:0]  STEP_COUNT_RST = 5'd10;
	localparam logic [DIM_W-1:0]  FIELD_W_RST    = 9'd256;
	localparam logic [DIM_W-1:0]  FIELD_H_RST    = 9'd256;

	typedef logic signed [SUM_W-1:0] sum_t;

	typedef enum logic [3:0] {
		T_IDLE, T_WGO, T_WRAP, T_ADDR, T_READ, T_DATA, T_NORM, T_KMUL,
		T_NEXT, T_FIN1, T_FIN2, T_FIN3, T_BREAD, T_BEMIT, T_SEMIT
	} trace_state_t;

	typedef enum logic [2:0] {
		N_IDLE, N_SQ, N_SUM, N_SQRT, N_DIVSET, N_DIV, N_OUT
	} norm_state_t;

	typedef struct packed {
		logic               done;
		logic               in_range;
		logic [COORD_W-1:0] coord;
	} wrap_res_t;

	typedef struct packed {
		logic                     done;
		logic signed [UNIT_W-1:0] ux;
		logic signed [UNIT_W-1:0] uy;
	} norm_res_t;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W+1:0] v);
		if (v > 26'sd8388607)
			return 24'sh7FFFFF;
		if (v < -26'sd8388608)
			return 24'sh800000;
		return v[POS_W-1:0];
	endfunction

	// Divide by 2^14 or 2^15 with rounding half away from zero.
	function automatic logic signed [15:0] rnd_shr(input logic signed [K_W-1:0] k,
			input logic by14);
		logic [K_W-1:0] a;
		logic [K_W-1:0] r;
		logic signed [15:0] m;
		a = k[K_W-1] ? K_W'(-k) : K_W'(k);
		r = by14 ? ((a + 28'd8192) >> 14) : ((a + 28'd16384) >> 15);
		m = 16'(r);
		return k[K_W-1] ? -m : m;
	endfunction

endpackage

>>> sv/rk4_streamline_tracer.sv
// Write words raise no busy; a trace word keeps busy high while each stage of every RK4
// step passes through the coordinate modulo, the field memory and the normalizer.
// Backward points leave one after another, the start point right after them, and each
// forward point as its step ends; the receiver cannot stall. Reset clears the sequencer
// and loads the register defaults; the field memory holds garbage until written.
module rk4_streamline_tracer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic                                action,
	input  logic [rkst_pkg::ADDR_W-1:0]         cell_index,
	input  logic signed [rkst_pkg::VEC_W-1:0]   vec_x,
	input  logic signed [rkst_pkg::VEC_W-1:0]   vec_y,
	input  logic signed [rkst_pkg::POS_W-1:0]   start_x,
	input  logic signed [rkst_pkg::POS_W-1:0]   start_y,
	input  logic                                cfg_we,
	input  logic [1:0]                          cfg_index,
	input  logic [rkst_pkg::STEP_W-1:0]         cfg_data,
	output logic                                strobe,
	output logic signed [rkst_pkg::POS_W-1:0]   point_x,
	output logic signed [rkst_pkg::POS_W-1:0]   point_y,
	output logic [rkst_pkg::PNUM_W-1:0]         point_number,
	output logic                                last_point
);

	rkst_pkg::trace_state_t state_q, state_d;

	logic [rkst_pkg::STEP_W-1:0] step_size_q;
	logic [rkst_pkg::CNT_W-1:0]  step_count_q;
	logic [rkst_pkg::DIM_W-1:0]  field_w_q, field_h_q;

	logic [2*rkst_pkg::VEC_W-1:0] fld_mem [rkst_pkg::FIELD_DEPTH];
	logic [2*rkst_pkg::VEC_W-1:0] fld_rd_q;
	logic [2*rkst_pkg::POS_W-1:0] bk_mem [rkst_pkg::MAX_STEPS];
	logic [2*rkst_pkg::POS_W-1:0] bk_rd_q;

	logic signed [rkst_pkg::POS_W-1:0] x0_q, y0_q, px_q, py_q, qx_q, qy_q;
	logic                              fwd_q;
	logic [1:0]                        stage_q;
	logic [rkst_pkg::CNT_W-1:0]        idx_q;
	logic [rkst_pkg::PNUM_W-1:0]       pnum_q;
	logic [rkst_pkg::ADDR_W-1:0]       addr_q;
	logic                              ok_q;
	logic signed [rkst_pkg::K_W-1:0]   kx_q, ky_q;
	logic signed [rkst_pkg::SUM_W-1:0] sumx_q, sumy_q;
	logic [16:0]                       tx_q, ty_q;
	logic [14:0]                       dx_q, dy_q;

	logic                              strobe_q, last_q;
	logic signed [rkst_pkg::POS_W-1:0] ox_q, oy_q;
	logic [rkst_pkg::PNUM_W-1:0]       onum_q;

	logic                wrap_go, norm_go;
	rkst_pkg::wrap_res_t wx, wy;
	rkst_pkg::norm_res_t nres;
	logic signed [rkst_pkg::VEC_W-1:0] nvx, nvy;

	logic signed [12:0]                h;
	logic signed [rkst_pkg::K_W:0]     mulx, muly;
	logic signed [rkst_pkg::SUM_W-1:0] wkx, wky;
	logic [rkst_pkg::SUM_W-1:0]        absx, absy;
	logic [32:0]                       recx, recy;
	logic signed [rkst_pkg::POS_W-1:0] npx, npy, sqx, sqy;
	logic signed [15:0]                rdx, rdy;
	logic                              last_step;
	logic [rkst_pkg::CNT_W-1:0]        cv;
	logic [rkst_pkg::DIM_W-1:0]        dv;

	rkst_wrap u_wrap_x (.clk, .arst_n, .go(wrap_go), .pos(qx_q), .size(field_w_q), .res(wx));
	rkst_wrap u_wrap_y (.clk, .arst_n, .go(wrap_go), .pos(qy_q), .size(field_h_q), .res(wy));
	rkst_norm u_norm (.clk, .arst_n, .go(norm_go), .vx(nvx), .vy(nvy), .res(nres));

	always_comb begin
		h = fwd_q ? $signed({1'b0, step_size_q}) : -$signed({1'b0, step_size_q});
		nvx = ok_q ? $signed(fld_rd_q[31:16]) : '0;
		nvy = ok_q ? $signed(fld_rd_q[15:0]) : '0;
		mulx = nres.ux * h;
		muly = nres.uy * h;
		// The middle two stages carry double weight in the RK4 sum.
		wkx = (stage_q == 2'd1 || stage_q == 2'd2) ? rkst_pkg::sum_t'(kx_q) <<< 1 :
			rkst_pkg::sum_t'(kx_q);
		wky = (stage_q == 2'd1 || stage_q == 2'd2) ? rkst_pkg::sum_t'(ky_q) <<< 1 :
			rkst_pkg::sum_t'(ky_q);
		rdx = rkst_pkg::rnd_shr(kx_q, stage_q == 2'd2);
		rdy = rkst_pkg::rnd_shr(ky_q, stage_q == 2'd2);
		sqx = rkst_pkg::sat_pos(26'(px_q) + 26'(rdx));
		sqy = rkst_pkg::sat_pos(26'(py_q) + 26'(rdy));
		absx = sumx_q[rkst_pkg::SUM_W-1] ? -sumx_q : sumx_q;
		absy = sumy_q[rkst_pkg::SUM_W-1] ? -sumy_q : sumy_q;
		// Division by 6 as a multiply by the reciprocal; exact below 2^17.
		recx = tx_q * 16'd43691;
		recy = ty_q * 16'd43691;
		npx = rkst_pkg::sat_pos(26'(px_q) + (sumx_q[rkst_pkg::SUM_W-1] ?
			-26'(dx_q) : 26'(dx_q)));
		npy = rkst_pkg::sat_pos(26'(py_q) + (sumy_q[rkst_pkg::SUM_W-1] ?
			-26'(dy_q) : 26'(dy_q)));
		last_step = (idx_q == step_count_q - 5'd1);
		cv = cfg_data[rkst_pkg::CNT_W-1:0];
		dv = cfg_data[rkst_pkg::DIM_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		wrap_go = 1'b0;
		norm_go = 1'b0;
		case (state_q)
			rkst_pkg::T_IDLE: if (start && action) state_d = rkst_pkg::T_WGO;
			rkst_pkg::T_WGO: begin
				wrap_go = 1'b1;
				state_d = rkst_pkg::T_WRAP;
			end
			rkst_pkg::T_WRAP: if (wx.done) state_d = rkst_pkg::T_ADDR;
			rkst_pkg::T_ADDR: state_d = rkst_pkg::T_READ;
			rkst_pkg::T_READ: state_d = rkst_pkg::T_DATA;
			rkst_pkg::T_DATA: begin
				norm_go = 1'b1;
				state_d = rkst_pkg::T_NORM;
			end
			rkst_pkg::T_NORM: if (nres.done) state_d = rkst_pkg::T_KMUL;
			rkst_pkg::T_KMUL: state_d = rkst_pkg::T_NEXT;
			rkst_pkg::T_NEXT: state_d = (stage_q == 2'd3) ? rkst_pkg::T_FIN1 : rkst_pkg::T_WGO;
			rkst_pkg::T_FIN1: state_d = rkst_pkg::T_FIN2;
			rkst_pkg::T_FIN2: state_d = rkst_pkg::T_FIN3;
			rkst_pkg::T_FIN3: begin
				if (!last_step)
					state_d = rkst_pkg::T_WGO;
				else if (fwd_q)
					state_d = rkst_pkg::T_IDLE;
				else
					state_d = rkst_pkg::T_BREAD;
			end
			rkst_pkg::T_BREAD: state_d = rkst_pkg::T_BEMIT;
			rkst_pkg::T_BEMIT: state_d = (idx_q == '0) ? rkst_pkg::T_SEMIT : rkst_pkg::T_BREAD;
			rkst_pkg::T_SEMIT: state_d = rkst_pkg::T_WGO;
			default: state_d = rkst_pkg::T_IDLE;
		endcase
	end

	assign busy = (state_q != rkst_pkg::T_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rkst_pkg::T_IDLE;
			strobe_q <= 1'b0;
			step_size_q <= rkst_pkg::STEP_SIZE_RST;
			step_count_q <= rkst_pkg::STEP_COUNT_RST;
			field_w_q <= rkst_pkg::FIELD_W_RST;
			field_h_q <= rkst_pkg::FIELD_H_RST;
		end else begin
			state_q <= state_d;
			strobe_q <= (state_q == rkst_pkg::T_BEMIT) || (state_q == rkst_pkg::T_SEMIT) ||
				((state_q == rkst_pkg::T_FIN3) && fwd_q);
			if (cfg_we) begin
				case (cfg_index)
					rkst_pkg::CFG_STEP_SIZE:
						step_size_q <= (cfg_data == '0) ? 12'd1 : cfg_data;
					rkst_pkg::CFG_STEP_COUNT:
						step_count_q <= (cv == '0) ? 5'd1 : cv;
					rkst_pkg::CFG_FIELD_WIDTH:
						field_w_q <= (dv == '0) ? 9'd1 :
							(dv > 9'(rkst_pkg::MAX_FIELD_W)) ? 9'(rkst_pkg::MAX_FIELD_W) : dv;
					rkst_pkg::CFG_FIELD_HEIGHT:
						field_h_q <= (dv == '0) ? 9'd1 :
							(dv > 9'(rkst_pkg::MAX_FIELD_H)) ? 9'(rkst_pkg::MAX_FIELD_H) : dv;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rkst_pkg::T_IDLE && start && !action)
			fld_mem[cell_index] <= {vec_x, vec_y};
		if (state_q == rkst_pkg::T_READ)
			fld_rd_q <= fld_mem[addr_q];
		if (state_q == rkst_pkg::T_FIN3 && !fwd_q)
			bk_mem[idx_q] <= {npx, npy};
		if (state_q == rkst_pkg::T_BREAD)
			bk_rd_q <= bk_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rkst_pkg::T_IDLE: begin
				x0_q <= start_x;
				y0_q <= start_y;
				px_q <= start_x;
				py_q <= start_y;
				qx_q <= start_x;
				qy_q <= start_y;
				fwd_q <= 1'b0;
				stage_q <= '0;
				idx_q <= '0;
				pnum_q <= '0;
			end
			rkst_pkg::T_ADDR: begin
				addr_q <= 16'(17'(wy.coord) * 17'(field_w_q)) + 16'(wx.coord);
				ok_q <= wx.in_range && wy.in_range;
			end
			rkst_pkg::T_KMUL: begin
				kx_q <= mulx[rkst_pkg::K_W-1:0];
				ky_q <= muly[rkst_pkg::K_W-1:0];
			end
			rkst_pkg::T_NEXT: begin
				sumx_q <= ((stage_q == 2'd0) ? '0 : sumx_q) + wkx;
				sumy_q <= ((stage_q == 2'd0) ? '0 : sumy_q) + wky;
				qx_q <= sqx;
				qy_q <= sqy;
				stage_q <= stage_q + 2'd1;
			end
			rkst_pkg::T_FIN1: begin
				tx_q <= 17'((absx + 31'd49152) >> 14);
				ty_q <= 17'((absy + 31'd49152) >> 14);
			end
			rkst_pkg::T_FIN2: begin
				dx_q <= recx[32:18];
				dy_q <= recy[32:18];
			end
			rkst_pkg::T_FIN3: begin
				px_q <= npx;
				py_q <= npy;
				qx_q <= npx;
				qy_q <= npy;
				if (fwd_q) begin
					ox_q <= npx;
					oy_q <= npy;
					onum_q <= pnum_q;
					last_q <= last_step;
					pnum_q <= pnum_q + 6'd1;
				end
				if (!last_step)
					idx_q <= idx_q + 5'd1;
			end
			rkst_pkg::T_BEMIT: begin
				ox_q <= bk_rd_q[47:24];
				oy_q <= bk_rd_q[23:0];
				onum_q <= pnum_q;
				last_q <= 1'b0;
				pnum_q <= pnum_q + 6'd1;
				if (idx_q != '0)
					idx_q <= idx_q - 5'd1;
			end
			rkst_pkg::T_SEMIT: begin
				ox_q <= x0_q;
				oy_q <= y0_q;
				onum_q <= pnum_q;
				last_q <= 1'b0;
				pnum_q <= pnum_q + 6'd1;
				fwd_q <= 1'b1;
				px_q <= x0_q;
				py_q <= y0_q;
				qx_q <= x0_q;
				qy_q <= y0_q;
				idx_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign strobe = strobe_q;
	assign point_x = ox_q;
	assign point_y = oy_q;
	assign point_number = onum_q;
	assign last_point = last_q;

endmodule

>>> sv/rkst_wrap.sv
// Wraps one position axis into a field coordinate with a bit-serial modulo.
// Depends on rkst_pkg.
module rkst_wrap (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  logic signed [rkst_pkg::POS_W-1:0] pos,
	input  logic [rkst_pkg::DIM_W-1:0]        size,
	output rkst_pkg::wrap_res_t               res
);

	logic [15:0]                  m_q;
	logic [rkst_pkg::DIM_W-1:0]   rem_q;
	logic                         neg_q;
	logic [3:0]                   cnt_q;
	logic                         run_q;
	logic                         done_q;

	logic signed [rkst_pkg::POS_W:0] pe;
	logic signed [rkst_pkg::POS_W:0] ab;
	logic [16:0]                     ipm;
	logic signed [17:0]              ip;
	logic signed [17:0]              s;
	logic signed [17:0]              smag;
	logic [rkst_pkg::DIM_W:0]        remsh;
	logic [rkst_pkg::DIM_W:0]        remn;

	always_comb begin
		pe = {pos[rkst_pkg::POS_W-1], pos};
		ab = pos[rkst_pkg::POS_W-1] ? -pe : pe;
		ipm = ab[rkst_pkg::POS_W:8];
		ip = pos[rkst_pkg::POS_W-1] ? -$signed({1'b0, ipm}) : $signed({1'b0, ipm});
		s = ip + $signed({9'd0, size});
		smag = s[17] ? -s : s;
		remsh = {rem_q, m_q[15]};
		remn = (remsh >= {1'b0, size}) ? remsh - {1'b0, size} : remsh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= 4'd15;
			end else if (run_q) begin
				cnt_q <= cnt_q - 4'd1;
				if (cnt_q == 4'd0) begin
					run_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			m_q <= smag[15:0];
			neg_q <= s[17];
			rem_q <= '0;
		end else if (run_q) begin
			m_q <= {m_q[14:0], 1'b0};
			rem_q <= remn[rkst_pkg::DIM_W-1:0];
		end
	end

	// A negative sum is inside only when it is an exact multiple of the size.
	assign res.done = done_q;
	assign res.in_range = !neg_q || (rem_q == '0);
	assign res.coord = neg_q ? '0 : rem_q[rkst_pkg::COORD_W-1:0];

endmodule

>>> sv/rkst_norm.sv
// Normalizes a field sample to a Q1.14 unit vector: squares, a bit-serial
// square root and two restoring dividers. Depends on rkst_pkg.
module rkst_norm (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              go,
	input  logic signed [rkst_pkg::VEC_W-1:0] vx,
	input  logic signed [rkst_pkg::VEC_W-1:0] vy,
	output rkst_pkg::norm_res_t               res
);

	rkst_pkg::norm_state_t state_q, state_d;

	logic signed [rkst_pkg::VEC_W-1:0] vx_q, vy_q;
	logic [31:0]                       sqx_q, sqy_q;
	logic [59:0]                       n_q, r_q, bit_q;
	logic [4:0]                        cnt_q;
	logic [44:0]                       numx_q, numy_q, d_q;
	logic [15:0]                       qx_q, qy_q;
	logic signed [rkst_pkg::UNIT_W-1:0] ux_q, uy_q;
	logic                              done_q;

	logic signed [31:0] px, py;
	logic [31:0]        m2;
	logic [59:0]        trial;
	logic [16:0]        ax, ay;
	logic [15:0]        cx, cy;

	always_comb begin
		px = vx_q * vx_q;
		py = vy_q * vy_q;
		m2 = sqx_q + sqy_q;
		trial = r_q + bit_q;
		ax = vx_q[15] ? 17'(-$signed({vx_q[15], vx_q})) : {1'b0, vx_q};
		ay = vy_q[15] ? 17'(-$signed({vy_q[15], vy_q})) : {1'b0, vy_q};
		cx = (qx_q > 16'd16384) ? 16'd16384 : qx_q;
		cy = (qy_q > 16'd16384) ? 16'd16384 : qy_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rkst_pkg::N_IDLE:   if (go) state_d = rkst_pkg::N_SQ;
			rkst_pkg::N_SQ:     state_d = rkst_pkg::N_SUM;
			rkst_pkg::N_SUM:    state_d = (m2 == '0) ? rkst_pkg::N_IDLE : rkst_pkg::N_SQRT;
			rkst_pkg::N_SQRT:   if (cnt_q == '0) state_d = rkst_pkg::N_DIVSET;
			rkst_pkg::N_DIVSET: state_d = rkst_pkg::N_DIV;
			rkst_pkg::N_DIV:    if (cnt_q == '0) state_d = rkst_pkg::N_OUT;
			rkst_pkg::N_OUT:    state_d = rkst_pkg::N_IDLE;
			default:            state_d = rkst_pkg::N_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rkst_pkg::N_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (state_q == rkst_pkg::N_OUT) ||
				((state_q == rkst_pkg::N_SUM) && (m2 == '0));
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rkst_pkg::N_IDLE: begin
				vx_q <= vx;
				vy_q <= vy;
			end
			rkst_pkg::N_SQ: begin
				sqx_q <= px;
				sqy_q <= py;
			end
			rkst_pkg::N_SUM: begin
				n_q <= {m2[31:0], 28'd0};
				r_q <= '0;
				bit_q <= 60'd1 << 58;
				cnt_q <= 5'd29;
				ux_q <= '0;
				uy_q <= '0;
			end
			rkst_pkg::N_SQRT: begin
				if (n_q >= trial) begin
					n_q <= n_q - trial;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
				cnt_q <= cnt_q - 5'd1;
			end
			rkst_pkg::N_DIVSET: begin
				// Adding half the divisor gives rounding half away from zero.
				numx_q <= {ax, 28'd0} + 45'(r_q[29:1]);
				numy_q <= {ay, 28'd0} + 45'(r_q[29:1]);
				d_q <= {r_q[29:0], 15'd0};
				qx_q <= '0;
				qy_q <= '0;
				cnt_q <= 5'd15;
			end
			rkst_pkg::N_DIV: begin
				if (numx_q >= d_q) begin
					numx_q <= numx_q - d_q;
					qx_q <= {qx_q[14:0], 1'b1};
				end else begin
					qx_q <= {qx_q[14:0], 1'b0};
				end
				if (numy_q >= d_q) begin
					numy_q <= numy_q - d_q;
					qy_q <= {qy_q[14:0], 1'b1};
				end else begin
					qy_q <= {qy_q[14:0], 1'b0};
				end
				d_q <= d_q >> 1;
				cnt_q <= cnt_q - 5'd1;
			end
			rkst_pkg::N_OUT: begin
				ux_q <= vx_q[15] ? -$signed(cx) : $signed(cx);
				uy_q <= vy_q[15] ? -$signed(cy) : $signed(cy);
			end
			default: begin
			end
		endcase
	end

	assign res.done = done_q;
	assign res.ux = ux_q;
	assign res.uy = uy_q;

endmodule

>>> bench/tb.sv
// Self-checking bench for rk4_streamline_tracer: cell writes, streamline traces, register phases.
// Depends on rkst_pkg and the tracer RTL; a scoreboard class predicts every streamline point.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rkst_pkg::*;

	localparam int LIMIT_CYCLES = 40000000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct {
		logic signed [POS_W-1:0]  x;
		logic signed [POS_W-1:0]  y;
		logic [PNUM_W-1:0]        num;
		logic                     last;
	} point_t;

	class trace_scoreboard;
		logic signed [VEC_W-1:0] field_x [FIELD_DEPTH];
		logic signed [VEC_W-1:0] field_y [FIELD_DEPTH];
		longint step_len, steps, fw, fh;
		point_t pending[$];
		int errors, traces, points, cell_writes;

		function new();
			step_len = 256;
			steps = 10;
			fw = 256;
			fh = 256;
		endfunction

		function void report(string what, longint got, longint want);
			errors++;
			$display("ERROR %s: got %0d, expected %0d", what, got, want);
		endfunction

		function void set_reg(logic [1:0] idx, logic [STEP_W-1:0] data);
			longint v;
			case (idx)
				CFG_STEP_SIZE: begin
					v = data;
					step_len = (v == 0) ? 1 : v;
				end
				CFG_STEP_COUNT: begin
					v = data[CNT_W-1:0];
					steps = (v == 0) ? 1 : v;
				end
				CFG_FIELD_WIDTH: begin
					v = data[DIM_W-1:0];
					fw = (v == 0) ? 1 : (v > MAX_FIELD_W) ? MAX_FIELD_W : v;
				end
				CFG_FIELD_HEIGHT: begin
					v = data[DIM_W-1:0];
					fh = (v == 0) ? 1 : (v > MAX_FIELD_H) ? MAX_FIELD_H : v;
				end
				default: begin
				end
			endcase
		endfunction

		function longint rnd_div(longint n, longint d);
			if (n >= 0)
				return (n + d / 2) / d;
			return -((-n + d / 2) / d);
		endfunction

		function longint clamp_pos(longint v);
			if (v > 8388607)
				return 8388607;
			if (v < -8388608)
				return -8388608;
			return v;
		endfunction

		function longint root(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n)
				b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else
					r >>= 1;
				b >>= 2;
			end
			return r;
		endfunction

		// A negative sum that is an exact multiple of the size still counts as inside.
		function longint fold(longint p, longint size, inout bit ok);
			longint ip, s;
			ip = (p >= 0) ? (p >>> 8) : -((-p) >>> 8);
			s = ip + size;
			if (s >= 0)
				return s % size;
			if (((-s) % size) != 0)
				ok = 0;
			return 0;
		endfunction

		function void unit_at(longint px, longint py, output longint ux, output longint uy);
			bit ok;
			longint cx, cy, vx, vy, a, b;
			longint unsigned m2, mag;
			ok = 1;
			vx = 0;
			vy = 0;
			cx = fold(px, fw, ok);
			cy = fold(py, fh, ok);
			if (ok) begin
				a = (cy * fw + cx) & 16'hFFFF;
				vx = field_x[a];
				vy = field_y[a];
			end
			ux = 0;
			uy = 0;
			m2 = vx * vx + vy * vy;
			if (m2 == 0)
				return;
			mag = root(m2 << 28);
			a = rnd_div(vx <<< 28, mag);
			b = rnd_div(vy <<< 28, mag);
			ux = (a > 16384) ? 16384 : (a < -16384) ? -16384 : a;
			uy = (b > 16384) ? 16384 : (b < -16384) ? -16384 : b;
		endfunction

		function void advance(inout longint px, inout longint py, input longint h);
			longint ux, uy, k1x, k1y, k2x, k2y, k3x, k3y, k4x, k4y;
			unit_at(px, py, ux, uy);
			k1x = ux * h;
			k1y = uy * h;
			unit_at(clamp_pos(px + rnd_div(k1x, 32768)), clamp_pos(py + rnd_div(k1y, 32768)),
				ux, uy);
			k2x = ux * h;
			k2y = uy * h;
			unit_at(clamp_pos(px + rnd_div(k2x, 32768)), clamp_pos(py + rnd_div(k2y, 32768)),
				ux, uy);
			k3x = ux * h;
			k3y = uy * h;
			unit_at(clamp_pos(px + rnd_div(k3x, 16384)), clamp_pos(py + rnd_div(k3y, 16384)),
				ux, uy);
			k4x = ux * h;
			k4y = uy * h;
			px = clamp_pos(px + rnd_div(k1x + 2 * k2x + 2 * k3x + k4x, 6 * 16384));
			py = clamp_pos(py + rnd_div(k1y + 2 * k2y + 2 * k3y + k4y, 6 * 16384));
		endfunction

		function void push_point(longint x, longint y, int n, bit last);
			point_t p;
			p.x = x[POS_W-1:0];
			p.y = y[POS_W-1:0];
			p.num = n[PNUM_W-1:0];
			p.last = last;
			pending.push_back(p);
		endfunction

		function void note_word(logic act, logic [ADDR_W-1:0] idx,
				logic signed [VEC_W-1:0] vx, logic signed [VEC_W-1:0] vy,
				logic signed [POS_W-1:0] sx, logic signed [POS_W-1:0] sy);
			longint bx [MAX_STEPS];
			longint by [MAX_STEPS];
			longint x0, y0, wx, wy;
			int n;
			if (!act) begin
				field_x[idx] = vx;
				field_y[idx] = vy;
				cell_writes++;
				return;
			end
			traces++;
			x0 = sx;
			y0 = sy;
			wx = x0;
			wy = y0;
			for (int i = 0; i < steps; i++) begin
				advance(wx, wy, -step_len);
				bx[i] = wx;
				by[i] = wy;
			end
			n = 0;
			for (int i = steps - 1; i >= 0; i--)
				push_point(bx[i], by[i], n++, 0);
			push_point(x0, y0, n++, 0);
			wx = x0;
			wy = y0;
			for (int i = 0; i < steps; i++) begin
				advance(wx, wy, step_len);
				push_point(wx, wy, n++, i == steps - 1);
			end
		endfunction

		function void check_point(logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
				logic [PNUM_W-1:0] num, logic last);
			point_t p;
			points++;
			if (pending.size() == 0) begin
				report("unexpected point, number", num, -1);
				return;
			end
			p = pending.pop_front();
			if (x !== p.x)
				report($sformatf("point_x of point %0d", p.num), x, p.x);
			if (y !== p.y)
				report($sformatf("point_y of point %0d", p.num), y, p.y);
			if (num !== p.num)
				report("point_number", num, p.num);
			if (last !== p.last)
				report($sformatf("last_point of point %0d", p.num), last, p.last);
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic                     action;
	logic [ADDR_W-1:0]        cell_index;
	logic signed [VEC_W-1:0]  vec_x;
	logic signed [VEC_W-1:0]  vec_y;
	logic signed [POS_W-1:0]  start_x;
	logic signed [POS_W-1:0]  start_y;
	logic                     cfg_we;
	logic [1:0]               cfg_index;
	logic [STEP_W-1:0]        cfg_data;
	logic                     strobe;
	logic signed [POS_W-1:0]  point_x;
	logic signed [POS_W-1:0]  point_y;
	logic [PNUM_W-1:0]        point_number;
	logic                     last_point;

	trace_scoreboard sb = new();
	longint cycles = 0;
	bit quiet = 0;

	rk4_streamline_tracer i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.cell_index(cell_index), .vec_x(vec_x), .vec_y(vec_y),
		.start_x(start_x), .start_y(start_y),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .point_x(point_x), .point_y(point_y),
		.point_number(point_number), .last_point(last_point)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("rk4_streamline_tracer: mismatch");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_word(action, cell_index, vec_x, vec_y, start_x, start_y);
			if (strobe)
				sb.check_point(point_x, point_y, point_number, last_point);
		end
	end

	// Called at a falling edge; returns at a falling edge once the word is taken, at times after a random pause.
	task automatic send(logic act, logic [ADDR_W-1:0] idx, logic signed [VEC_W-1:0] vx,
			logic signed [VEC_W-1:0] vy, logic signed [POS_W-1:0] sx,
			logic signed [POS_W-1:0] sy);
		while (busy) begin
			start <= 0;
			@(negedge clk);
		end
		action <= act;
		cell_index <= idx;
		vec_x <= vx;
		vec_y <= vy;
		start_x <= sx;
		start_y <= sy;
		start <= 1;
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			start <= 0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
	endtask

	task automatic write_cell(logic [ADDR_W-1:0] idx, logic signed [VEC_W-1:0] vx,
			logic signed [VEC_W-1:0] vy);
		send(0, idx, vx, vy, $urandom, $urandom);
	endtask

	task automatic trace(logic signed [POS_W-1:0] sx, logic signed [POS_W-1:0] sy);
		send(1, $urandom, $urandom, $urandom, sx, sy);
	endtask

	task automatic settle();
		start <= 0;
		@(negedge clk);
		while (busy || sb.pending.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_regs(int unsigned s, int unsigned c, int unsigned w, int unsigned h);
		logic [STEP_W-1:0] vals [4];
		logic [1:0] idxs [4];
		vals = '{s, c, w, h};
		idxs = '{CFG_STEP_SIZE, CFG_STEP_COUNT, CFG_FIELD_WIDTH, CFG_FIELD_HEIGHT};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1;
			cfg_index <= idxs[i];
			cfg_data <= vals[i];
			sb.set_reg(idxs[i], vals[i]);
			@(negedge clk);
		end
		cfg_we <= 0;
		@(negedge clk);
	endtask

	function automatic logic signed [VEC_W-1:0] rand_comp();
		if ($urandom_range(0, 1))
			return $urandom;
		return $signed($urandom_range(0, 600)) - 300;
	endfunction

	// Random words for one register setting: cell writes and traces in equal shares, most traces starting near the field.
	task automatic random_phase(int n);
		int span_x, span_y;
		span_x = sb.fw * 256;
		span_y = sb.fh * 256;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 1)) begin
				if ($urandom_range(0, 3) == 0)
					write_cell($urandom, rand_comp(), rand_comp());
				else
					write_cell($urandom_range(0, 255), rand_comp(), rand_comp());
			end else if ($urandom_range(0, 4) == 0)
				trace($urandom, $urandom);
			else
				trace($signed($urandom_range(0, 3 * span_x)) - span_x,
					$signed($urandom_range(0, 3 * span_y)) - span_y);
		end
		settle();
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		action = 0;
		cell_index = 0;
		vec_x = 0;
		vec_y = 0;
		start_x = 0;
		start_y = 0;
		cfg_we = 0;
		cfg_index = CFG_STEP_SIZE;
		cfg_data = 0;
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Only cells below 256 are ever sampled, since every setting keeps width*height <= 256.
		set_regs(256, 2, 16, 16);
		for (int c = 0; c < 256; c++)
			write_cell(c, rand_comp(), rand_comp());
		write_cell(0, 16'sh7FFF, 16'sh8000);
		write_cell(1, 0, 0);
		write_cell(2, 16'sh8000, 16'sh8000);
		write_cell(17, 1, 0);
		write_cell(16'hFFFF, 16'sh7FFF, 16'sh7FFF);
		trace(0, 0);
		trace(24'sh000100, 0);
		trace(24'sh000200, 0);
		trace(24'sh001100, 24'sh000100);
		trace(24'sh7FFFFF, 24'sh7FFFFF);
		trace(24'sh800000, 24'sh800000);
		trace(24'sh7FFFFF, 24'sh800000);
		trace(-1, -1);
		trace(-16 * 256, 0);
		trace(-17 * 256, -17 * 256);
		trace(24'sh0FFF, 24'sh0FFF);
		settle();

		set_regs(4095, 3, 256, 1);
		random_phase(28);
		set_regs(0, 0, 1, 256);
		random_phase(28);
		set_regs(1, 2, 0, 0);
		random_phase(28);
		set_regs(2048, 31, 511, 1);
		random_phase(6);
		set_regs(37, 4, 7, 13);
		random_phase(28);
		set_regs(1000, 2, 16, 16);
		random_phase(28);
		quiet = 1;
		set_regs(300, 3, 5, 50);
		random_phase(28);

		$display("Covered %0d cell writes and %0d traces, %0d points checked.",
			sb.cell_writes, sb.traces, sb.points);
		$display("Register settings swept step sizes 1..4095, step counts 1..31, fields 1..256.");
		if (sb.errors == 0)
			$display("rk4_streamline_tracer: match");
		else
			$display("rk4_streamline_tracer: mismatch");
		$finish;
	end
endmodule

>>> rk4_streamline_tracer.f
sv/rkst_pkg.sv
sv/rkst_wrap.sv
sv/rkst_norm.sv
sv/rk4_streamline_tracer.sv
bench/tb.sv
